### rtl/core/rpfa_pkg.sv
// shared types, codes and defaults for the refcounted page frame allocator
package rpfa_pkg;

  localparam int ADDR_W = 36;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 32;

  localparam int                NUM_FRAMES_DEF = 32768;
  localparam int                PAGE_SHIFT_DEF = 12;
  localparam logic [ADDR_W-1:0] MEM_BASE_DEF   = 36'h0_8000_0000;

  localparam logic [CFG_W-1:0] FIRST_USABLE_RESET = 32'h8000_0000;
  localparam logic [CNT_W-1:0] COUNT_MAX          = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_INC   = 2'd2,
    FUNC_DEC   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2,
    ST_NEG = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] phys_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    status_t           status;
    logic [CNT_W-1:0]  ref_count;
    logic              frame_freed;
  } out_item_t;

  typedef struct packed {
    func_t op;
    logic  bad;
  } rpfa_cmd_t;

endpackage

### rtl/core/rpfa_front.sv
// front end: config register, request classification and the command queue
module rpfa_front import rpfa_pkg::*; #(
  parameter int                NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int                PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter logic [ADDR_W-1:0] MEM_BASE   = MEM_BASE_DEF,
  localparam int               FW         = $clog2(NUM_FRAMES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             blocked,
  output logic             q_valid,
  output rpfa_cmd_t        q_cmd,
  output logic [FW-1:0]    q_frame,
  input  logic             q_pop
);

  localparam int EXT_W = ADDR_W + 2;
  localparam int QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [EXT_W-1:0] PHYS_STOP =
    EXT_W'(MEM_BASE) + (EXT_W'(NUM_FRAMES) << PAGE_SHIFT);

  logic [CFG_W-1:0]  first_usable_r;
  logic [ADDR_W-1:0] pa;
  logic [ADDR_W-1:0] offs;
  logic              in_range;
  logic              aligned;
  logic              above_fu;
  rpfa_cmd_t         cmd;
  logic [FW-1:0]     frame;
  logic              push;

  rpfa_cmd_t     cmd_mem   [QUEUE_DEPTH];
  logic [FW-1:0] frame_mem [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_usable_r <= FIRST_USABLE_RESET;
    end else if (cfg_we) begin
      first_usable_r <= cfg_wdata;
    end
  end

  assign pa       = in_data.phys_addr;
  assign offs     = pa - MEM_BASE;
  assign frame    = FW'(offs >> PAGE_SHIFT);
  assign in_range = (pa >= MEM_BASE) && ({2'b00, pa} < PHYS_STOP);
  assign aligned  = (pa[PAGE_SHIFT-1:0] == '0);
  assign above_fu = (pa >= ADDR_W'(first_usable_r));

  always_comb begin
    cmd.op  = in_data.func;
    cmd.bad = 1'b0;
    unique case (in_data.func)
      FUNC_ALLOC: cmd.bad = 1'b0;
      FUNC_FREE:  cmd.bad = !(aligned && above_fu && in_range);
      FUNC_INC,
      FUNC_DEC:   cmd.bad = !in_range;
    endcase
  end

  assign in_ready = (count_r != QCW'(QUEUE_DEPTH)) && !blocked;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = cmd_mem[rd_ptr_r];
  assign q_frame  = frame_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr_r]   <= cmd;
      frame_mem[wr_ptr_r] <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (q_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/rpfa_back.sv
// back end: count table, free stack, read-modify-write sequencer and result register
module rpfa_back import rpfa_pkg::*; #(
  parameter int                NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int                PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter logic [ADDR_W-1:0] MEM_BASE   = MEM_BASE_DEF,
  localparam int               FW         = $clog2(NUM_FRAMES)
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          clearing,
  input  logic          q_valid,
  input  rpfa_cmd_t     q_cmd,
  input  logic [FW-1:0] q_frame,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  localparam int TW = $clog2(NUM_FRAMES + 1);
  localparam longint unsigned PAGE = 64'd1 << PAGE_SHIFT;
  localparam longint unsigned FU   = 64'(FIRST_USABLE_RESET);
  localparam longint unsigned MB   = 64'(MEM_BASE);
  localparam longint unsigned F0_RAW = (FU > MB) ? ((FU - MB + PAGE - 1) >> PAGE_SHIFT) : 64'd0;
  localparam longint unsigned F0 =
    (F0_RAW > 64'(NUM_FRAMES)) ? 64'(NUM_FRAMES) : F0_RAW;
  localparam logic [TW-1:0] USABLE = TW'(64'(NUM_FRAMES) - F0);

  typedef enum logic [2:0] {
    S_CLR = 3'b001,
    S_RD  = 3'b010,
    S_EX  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [FW-1:0]    stk_mem [NUM_FRAMES];
  logic [CNT_W-1:0] cnt_mem [NUM_FRAMES];

  logic [FW-1:0]    clr_idx_r;
  logic [TW-1:0]    top_r, min_top_r;
  logic [TW-1:0]    top_m1;
  rpfa_cmd_t        cur_cmd_r;
  logic [FW-1:0]    cur_frame_r;
  logic             pris_r;
  logic [FW-1:0]    pris_frame_r;
  logic [FW-1:0]    stk_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic [CNT_W-1:0] cnt_dec, cnt_inc;

  logic             ex_go;
  out_item_t        res;
  logic             cnt_wen;
  logic [CNT_W-1:0] cnt_wdv;
  logic [FW-1:0]    ex_frame;
  logic             do_push, do_pop;
  logic             cnt_we;
  logic [FW-1:0]    cnt_wa;
  logic [CNT_W-1:0] cnt_wd;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign clearing = (state_r == S_CLR);
  assign q_pop    = (state_r == S_RD) && q_valid;
  assign ex_go    = (state_r == S_EX) && (!out_valid_r || out_ready);
  assign top_m1   = top_r - 1'b1;
  assign cnt_dec  = cnt_rd_r - 1'b1;
  assign cnt_inc  = (cnt_rd_r == COUNT_MAX) ? cnt_rd_r : cnt_rd_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: if (clr_idx_r == FW'(NUM_FRAMES - 1)) state_nxt = S_RD;
      S_RD:  if (q_valid) state_nxt = S_EX;
      S_EX:  if (ex_go) state_nxt = S_RD;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    cnt_wen     = 1'b0;
    cnt_wdv     = '0;
    ex_frame    = cur_frame_r;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    if (cur_cmd_r.bad) begin
      res.status = ST_BAD;
    end else begin
      unique case (cur_cmd_r.op)
        FUNC_ALLOC: begin
          if (top_r == '0) begin
            res.status = ST_OOM;
          end else begin
            ex_frame       = pris_r ? pris_frame_r : stk_rd_r;
            cnt_wen        = 1'b1;
            cnt_wdv        = CNT_W'(1);
            do_pop         = 1'b1;
            res.ref_count  = CNT_W'(1);
            res.alloc_addr = MEM_BASE + (ADDR_W'(ex_frame) << PAGE_SHIFT);
          end
        end
        FUNC_FREE: begin
          if (cnt_rd_r == '0) begin
            res.status = ST_NEG;
          end else begin
            cnt_wen       = 1'b1;
            cnt_wdv       = cnt_dec;
            res.ref_count = cnt_dec;
            if (cnt_dec == '0 && top_r < TW'(NUM_FRAMES)) begin
              do_push         = 1'b1;
              res.frame_freed = 1'b1;
            end
          end
        end
        FUNC_INC: begin
          cnt_wen       = 1'b1;
          cnt_wdv       = cnt_inc;
          res.ref_count = cnt_inc;
        end
        FUNC_DEC: begin
          if (cnt_rd_r == '0) begin
            res.status = ST_NEG;
          end else begin
            cnt_wen       = 1'b1;
            cnt_wdv       = cnt_dec;
            res.ref_count = cnt_dec;
          end
        end
      endcase
    end
  end

  assign cnt_we = clearing || (ex_go && cnt_wen);
  assign cnt_wa = clearing ? clr_idx_r : ex_frame;
  assign cnt_wd = clearing ? '0 : cnt_wdv;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (q_pop) begin
      cnt_rd_r <= cnt_mem[q_frame];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go && do_push) begin
      stk_mem[top_r[FW-1:0]] <= cur_frame_r;
    end
    if (q_pop) begin
      stk_rd_r <= stk_mem[top_m1[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd_r    <= q_cmd;
      cur_frame_r  <= q_frame;
      pris_r       <= (top_m1 < min_top_r);
      pris_frame_r <= FW'(F0) + top_m1[FW-1:0];
    end
    if (ex_go) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      top_r       <= USABLE;
      min_top_r   <= USABLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (ex_go) begin
        if (do_pop) begin
          top_r <= top_m1;
          if (top_m1 < min_top_r) begin
            min_top_r <= top_m1;
          end
        end else if (do_push) begin
          top_r <= top_r + 1'b1;
        end
      end
      if (ex_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/refcounted_page_frame_allocator.sv
// top level of the refcounted page frame allocator
// result path: an accepted item is queued, read in S_RD, then executed and registered in S_EX once the output is free
// sequencing: the back end works on one item at a time, a read then modify-write pass
// over the count table and free stack memories, popping no new item until the last is done
// reset: a clearing pass over every frame zeroes the count table with in_ready low;
// the free stack reads its reset contents through a low-water mark, no pass needed
module refcounted_page_frame_allocator import rpfa_pkg::*; #(
  parameter int                NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int                PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter logic [ADDR_W-1:0] MEM_BASE   = MEM_BASE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int FW = $clog2(NUM_FRAMES);

  logic          clearing;
  logic          q_valid;
  rpfa_cmd_t     q_cmd;
  logic [FW-1:0] q_frame;
  logic          q_pop;

  rpfa_front #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MEM_BASE   (MEM_BASE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .blocked   (clearing),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_frame   (q_frame),
    .q_pop     (q_pop)
  );

  rpfa_back #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MEM_BASE   (MEM_BASE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_frame   (q_frame),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/rpfa_chk.sv
// port-level checker for the refcounted page frame allocator, with its bind
module rpfa_chk import rpfa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("item taken before the count table is cleared");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.alloc_addr == '0 && out_data.ref_count == '0 && !out_data.frame_freed)
    else $error("failed request carries nonzero fields");

  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_freed |->
      out_data.status == ST_OK && out_data.ref_count == '0 && out_data.alloc_addr == '0)
    else $error("frame pushed back with a live count");

endmodule

bind refcounted_page_frame_allocator rpfa_chk u_chk (.*);
